// ===== rtl/core/png_csw_pkg.sv =====
package png_csw_pkg;

    localparam int unsigned CountWidth = 33;

    localparam logic [1:0] STATUS_IEND     = 2'd0;
    localparam logic [1:0] STATUS_NO_IEND  = 2'd1;
    localparam logic [1:0] STATUS_BAD_SIG  = 2'd2;

    localparam logic [31:0] TYPE_IHDR = 32'h4948_4452;
    localparam logic [31:0] TYPE_IEND = 32'h4945_4E44;
    localparam logic [31:0] IHDR_BODY = 32'd13;
    localparam logic [CountWidth-1:0] CRC_BYTES = 33'd4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
    } png_byte_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] image_width;
        logic [31:0] image_height;
        logic        dims_ok;
    } png_result_t;

    function automatic logic [7:0] sig_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = 8'h89;
            3'd1:    b = 8'h50;
            3'd2:    b = 8'h4E;
            3'd3:    b = 8'h47;
            3'd4:    b = 8'h0D;
            3'd5:    b = 8'h0A;
            3'd6:    b = 8'h1A;
            3'd7:    b = 8'h0A;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// ===== rtl/core/png_chunk_stream_walker.sv =====
// PNG chunk stream walker.
// Byte channel (byte_valid / byte_stall / byte_beat): one beat carries one
// byte of a PNG file and an end_of_stream flag on its last byte. The block
// checks the 8-byte signature, walks chunk headers, skips chunk data and CRC,
// and captures width and height from a complete 13-byte IHDR body.
// Result channel (result_valid / result_stall / result_beat): at most one
// beat per file, at the IEND header, at end of stream, or on a bad or short
// signature. Later bytes are dropped until end of stream, which restarts the
// walk for a new file.
// Throughput is one byte per cycle while byte_stall is low; the parser state
// updates in the cycle a byte beat is taken. A result is registered in the
// output register, or in the skid register while the output beat is stalled.
// While the receiver stalls, the output register holds its beat and a skid
// register takes one more result; byte_stall rises only while the skid
// register is full.
// Reset clears the parser to expect a signature and empties both result
// registers.
module png_chunk_stream_walker
    import png_csw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    output logic        byte_stall,
    input  png_byte_t   byte_beat,
    output logic        result_valid,
    input  logic        result_stall,
    output png_result_t result_beat
);

    localparam logic [2:0] PH_SIG  = 3'd0;
    localparam logic [2:0] PH_HDR  = 3'd1;
    localparam logic [2:0] PH_IHDR = 3'd2;
    localparam logic [2:0] PH_SKIP = 3'd3;
    localparam logic [2:0] PH_DONE = 3'd4;

    logic [2:0]            phase_reg, phase_next;
    logic [CountWidth-1:0] count_reg, count_next, count_inc;
    logic [31:0]           len_reg, len_next;
    logic [31:0]           type_reg, type_next;
    logic [31:0]           width_reg, width_next;
    logic [31:0]           height_reg, height_next;
    logic [31:0]           wsh_reg, wsh_next;
    logic [31:0]           hsh_reg, hsh_next;

    logic        out_valid_reg, out_valid_next;
    png_result_t out_reg, out_next;
    logic        skid_valid_reg, skid_valid_next;
    png_result_t skid_reg, skid_next;

    logic        byte_fire;
    logic        out_fire;
    logic        res_valid;
    png_result_t res;

    assign byte_stall   = skid_valid_reg;
    assign byte_fire    = byte_valid && !skid_valid_reg;
    assign out_fire     = out_valid_reg && !result_stall;
    assign result_valid = out_valid_reg;
    assign result_beat  = out_reg;
    assign count_inc    = count_reg + 33'd1;

    always_comb
    begin
        phase_next  = phase_reg;
        count_next  = count_reg;
        len_next    = len_reg;
        type_next   = type_reg;
        width_next  = width_reg;
        height_next = height_reg;
        wsh_next    = wsh_reg;
        hsh_next    = hsh_reg;
        res_valid   = 1'b0;
        res.status  = STATUS_IEND;

        if (byte_fire)
        begin
            case (phase_reg)
                PH_SIG:
                begin
                    if (byte_beat.data_byte != sig_byte(count_reg[2:0]))
                    begin
                        res_valid  = 1'b1;
                        res.status = STATUS_BAD_SIG;
                        phase_next = PH_DONE;
                    end
                    else if (count_reg >= 33'd7)
                    begin
                        count_next = '0;
                        phase_next = PH_HDR;
                    end
                    else
                    begin
                        count_next = count_inc;
                        if (byte_beat.end_of_stream)
                        begin
                            res_valid  = 1'b1;
                            res.status = STATUS_BAD_SIG;
                            phase_next = PH_DONE;
                        end
                    end
                end
                PH_HDR:
                begin
                    if (count_reg < 33'd4)
                        len_next = {len_reg[23:0], byte_beat.data_byte};
                    else
                        type_next = {type_reg[23:0], byte_beat.data_byte};
                    count_next = count_inc;
                    if (count_inc >= 33'd8)
                    begin
                        if (type_next == TYPE_IEND)
                        begin
                            res_valid  = 1'b1;
                            res.status = STATUS_IEND;
                            phase_next = PH_DONE;
                        end
                        else if (type_next == TYPE_IHDR)
                        begin
                            count_next = '0;
                            phase_next = PH_IHDR;
                        end
                        else
                        begin
                            count_next = {1'b0, len_next} + CRC_BYTES;
                            phase_next = PH_SKIP;
                        end
                    end
                end
                PH_IHDR:
                begin
                    if (count_reg < 33'd4)
                        wsh_next = {wsh_reg[23:0], byte_beat.data_byte};
                    else if (count_reg < 33'd8)
                        hsh_next = {hsh_reg[23:0], byte_beat.data_byte};
                    count_next = count_inc;
                    if (count_inc >= {1'b0, IHDR_BODY})
                    begin
                        width_next  = wsh_next;
                        height_next = hsh_next;
                        if (len_reg > IHDR_BODY)
                            count_next = {1'b0, len_reg - IHDR_BODY} + CRC_BYTES;
                        else
                            count_next = CRC_BYTES;
                        phase_next = PH_SKIP;
                    end
                end
                PH_SKIP:
                begin
                    if (count_reg != '0)
                        count_next = count_reg - 33'd1;
                    if (count_next == '0)
                    begin
                        len_next   = '0;
                        type_next  = '0;
                        phase_next = PH_HDR;
                    end
                end
                default:
                begin
                end
            endcase

            if (byte_beat.end_of_stream && !res_valid && phase_next != PH_DONE)
            begin
                res_valid  = 1'b1;
                res.status = (phase_next == PH_SIG) ? STATUS_BAD_SIG : STATUS_NO_IEND;
            end
        end

        res.image_width  = width_next;
        res.image_height = height_next;
        res.dims_ok      = !width_next[31] && (width_next != '0) &&
                           !height_next[31] && (height_next != '0);

        if (byte_fire && byte_beat.end_of_stream)
        begin
            phase_next  = PH_SIG;
            count_next  = '0;
            len_next    = '0;
            type_next   = '0;
            width_next  = '0;
            height_next = '0;
            wsh_next    = '0;
            hsh_next    = '0;
        end
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (!out_valid_reg || out_fire)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = res_valid;
                out_next       = res;
            end
        end
        else if (res_valid)
        begin
            skid_valid_next = 1'b1;
            skid_next       = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_SIG;
            count_reg      <= '0;
            len_reg        <= '0;
            type_reg       <= '0;
            width_reg      <= '0;
            height_reg     <= '0;
            wsh_reg        <= '0;
            hsh_reg        <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            count_reg      <= count_next;
            len_reg        <= len_next;
            type_reg       <= type_next;
            width_reg      <= width_next;
            height_reg     <= height_next;
            wsh_reg        <= wsh_next;
            hsh_reg        <= hsh_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register full while output register empty");

    a_sig_count: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_SIG || phase_reg == PH_HDR) |-> count_reg < 33'd8)
        else $error("header byte count out of range");

    a_ihdr_count: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_IHDR |-> count_reg < {1'b0, IHDR_BODY})
        else $error("IHDR body count out of range");

    a_done_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (byte_fire && phase_reg == PH_DONE) |=> !skid_valid_reg || $past(skid_valid_reg))
        else $error("result produced after walk finished");

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import png_csw_pkg::*;

    typedef enum logic [2:0] {
        WALK_SIG,
        WALK_HDR,
        WALK_IHDR,
        WALK_SKIP,
        WALK_DONE
    } walk_phase_t;

    localparam logic [63:0] PNG_MAGIC = 64'h8950_4E47_0D0A_1A0A;
    localparam logic [31:0] TYPE_EXIF = 32'h6558_4966;
    localparam logic [31:0] TYPE_TEXT = 32'h7445_5874;
    localparam logic [31:0] TYPE_IDAT = 32'h4944_4154;
    localparam int RANDOM_BYTES = 720;
    localparam int RANDOM_QUIET_FROM = 620;
    localparam int STALL_LIMIT = 2000;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        byte_valid;
    logic        byte_stall;
    png_byte_t   byte_beat;
    logic        result_valid;
    logic        result_stall;
    png_result_t result_beat;

    png_chunk_stream_walker dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .byte_beat    (byte_beat),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_beat  (result_beat)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    walk_phase_t walk_phase;
    logic [32:0] walk_count;
    logic [31:0] hdr_length;
    logic [31:0] hdr_type;
    logic [31:0] dim_width;
    logic [31:0] dim_height;
    logic [31:0] acc_width;
    logic [31:0] acc_height;

    png_result_t expected_results[$];
    logic [7:0]  file_bytes[$];
    int          bytes_sent = 0;
    int          mismatch_count = 0;
    bit          idle_on = 1'b0;

    task automatic clear_walker();
        walk_phase = WALK_SIG;
        walk_count = '0;
        hdr_length = '0;
        hdr_type = '0;
        dim_width = '0;
        dim_height = '0;
        acc_width = '0;
        acc_height = '0;
    endtask

    function automatic logic [7:0] magic_byte(input int idx);
        return PNG_MAGIC[8 * (7 - idx) +: 8];
    endfunction

    task automatic predict_result(input logic [1:0] status);
        png_result_t r;
        r.status = status;
        r.image_width = dim_width;
        r.image_height = dim_height;
        r.dims_ok = !dim_width[31] && dim_width != '0 && !dim_height[31] && dim_height != '0;
        expected_results.push_back(r);
    endtask

    task automatic walk_byte(input png_byte_t beat);
        logic [7:0] b;
        bit         emitted;
        b = beat.data_byte;
        emitted = 1'b0;
        case (walk_phase)
            WALK_SIG:
            begin
                if (b != magic_byte(int'(walk_count[2:0])))
                begin
                    predict_result(STATUS_BAD_SIG);
                    emitted = 1'b1;
                    walk_phase = WALK_DONE;
                end
                else if (walk_count >= 33'd7)
                begin
                    walk_count = '0;
                    walk_phase = WALK_HDR;
                end
                else
                begin
                    walk_count = walk_count + 33'd1;
                    if (beat.end_of_stream)
                    begin
                        predict_result(STATUS_BAD_SIG);
                        emitted = 1'b1;
                        walk_phase = WALK_DONE;
                    end
                end
            end
            WALK_HDR:
            begin
                if (walk_count < 33'd4)
                    hdr_length = {hdr_length[23:0], b};
                else
                    hdr_type = {hdr_type[23:0], b};
                walk_count = walk_count + 33'd1;
                if (walk_count >= 33'd8)
                begin
                    if (hdr_type == TYPE_IEND)
                    begin
                        predict_result(STATUS_IEND);
                        emitted = 1'b1;
                        walk_phase = WALK_DONE;
                    end
                    else if (hdr_type == TYPE_IHDR)
                    begin
                        walk_count = '0;
                        walk_phase = WALK_IHDR;
                    end
                    else
                    begin
                        walk_count = {1'b0, hdr_length} + CRC_BYTES;
                        walk_phase = WALK_SKIP;
                    end
                end
            end
            WALK_IHDR:
            begin
                if (walk_count < 33'd4)
                    acc_width = {acc_width[23:0], b};
                else if (walk_count < 33'd8)
                    acc_height = {acc_height[23:0], b};
                walk_count = walk_count + 33'd1;
                if (walk_count >= {1'b0, IHDR_BODY})
                begin
                    dim_width = acc_width;
                    dim_height = acc_height;
                    walk_count = (hdr_length > IHDR_BODY)
                        ? {1'b0, hdr_length - IHDR_BODY} + CRC_BYTES : CRC_BYTES;
                    walk_phase = WALK_SKIP;
                end
            end
            WALK_SKIP:
            begin
                if (walk_count != '0)
                    walk_count = walk_count - 33'd1;
                if (walk_count == '0)
                begin
                    hdr_length = '0;
                    hdr_type = '0;
                    walk_phase = WALK_HDR;
                end
            end
            default:
            begin
            end
        endcase
        if (beat.end_of_stream)
        begin
            if (!emitted && walk_phase != WALK_DONE)
                predict_result(walk_phase == WALK_SIG ? STATUS_BAD_SIG : STATUS_NO_IEND);
            clear_walker();
        end
    endtask

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("%0t ERROR %s", $time, what);
    endtask

    always @(posedge clk)
    begin : check_results
        png_result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_results.size() == 0)
                report_mismatch("result beat with none expected");
            else
            begin
                want = expected_results.pop_front();
                if (result_beat.status !== want.status)
                    report_mismatch($sformatf("status got %0d want %0d",
                        result_beat.status, want.status));
                if (result_beat.image_width !== want.image_width)
                    report_mismatch($sformatf("image_width got %h want %h",
                        result_beat.image_width, want.image_width));
                if (result_beat.image_height !== want.image_height)
                    report_mismatch($sformatf("image_height got %h want %h",
                        result_beat.image_height, want.image_height));
                if (result_beat.dims_ok !== want.dims_ok)
                    report_mismatch($sformatf("dims_ok got %0d want %0d",
                        result_beat.dims_ok, want.dims_ok));
            end
        end
    end

    initial
    begin
        result_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (idle_on && $urandom_range(0, 5) == 0)
            begin
                result_stall <= 1'b1;
                repeat ($urandom_range(1, 10)) @(negedge clk);
                result_stall <= 1'b0;
            end
        end
    end

    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (byte_valid && !byte_stall) || (result_valid && !result_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Regression FAIL");
        $finish;
    end

    task automatic send_byte(input logic [7:0] b, input logic eos);
        png_byte_t beat;
        beat.data_byte = b;
        beat.end_of_stream = eos;
        if (idle_on && $urandom_range(0, 7) == 0)
        begin
            byte_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
        byte_valid <= 1'b1;
        byte_beat <= beat;
        do
            @(posedge clk);
        while (byte_stall);
        walk_byte(beat);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_file();
        int n;
        n = file_bytes.size();
        for (int i = 0; i < n; i++)
            send_byte(file_bytes[i], i == n - 1);
        file_bytes.delete();
    endtask

    task automatic put_word(input logic [31:0] w);
        for (int i = 3; i >= 0; i--)
            file_bytes.push_back(w[8 * i +: 8]);
    endtask

    task automatic put_random(input int n);
        for (int i = 0; i < n; i++)
            file_bytes.push_back(8'($urandom));
    endtask

    task automatic put_magic(input int n);
        for (int i = 0; i < n; i++)
            file_bytes.push_back(magic_byte(i));
    endtask

    task automatic put_chunk(input logic [31:0] len, input logic [31:0] kind);
        put_word(len);
        put_word(kind);
        put_random(int'(len) + 4);
    endtask

    task automatic put_ihdr(input logic [31:0] len, input logic [31:0] w,
                            input logic [31:0] h);
        put_word(len);
        put_word(TYPE_IHDR);
        put_word(w);
        put_word(h);
        put_random(5);
        put_random(len > IHDR_BODY ? int'(len - IHDR_BODY) + 4 : 4);
    endtask

    task automatic put_iend();
        put_word($urandom_range(0, 2));
        put_word(TYPE_IEND);
    endtask

    function automatic logic [31:0] pick_dim();
        case ($urandom_range(0, 6))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'h7FFF_FFFF;
            4:       return 32'h0000_0001;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_ihdr_length();
        case ($urandom_range(0, 5))
            0:       return $urandom_range(0, 12);
            1:       return $urandom_range(14, 24);
            default: return IHDR_BODY;
        endcase
    endfunction

    function automatic logic [31:0] pick_type();
        case ($urandom_range(0, 7))
            0:       return TYPE_EXIF;
            1:       return TYPE_TEXT;
            2:       return TYPE_IDAT;
            3:       return TYPE_IEND ^ (32'd1 << $urandom_range(0, 31));
            4:       return TYPE_IHDR ^ (32'd1 << $urandom_range(0, 31));
            default: return $urandom;
        endcase
    endfunction

    task automatic test_signature_errors();
        file_bytes.push_back(8'h00);
        send_file();
        put_magic(3);
        file_bytes.push_back(8'hFF);
        put_random(3);
        send_file();
        put_magic(2);
        send_file();
        put_magic(8);
        send_file();
    endtask

    task automatic test_iend_paths();
        put_magic(8);
        put_word(32'h0);
        put_word(TYPE_IEND);
        send_file();
        put_magic(8);
        put_chunk(32'd3, TYPE_TEXT);
        put_chunk(32'd2, TYPE_EXIF);
        put_chunk(32'd0, TYPE_IDAT);
        put_iend();
        put_random(3);
        send_file();
    endtask

    task automatic test_ihdr_variants();
        put_magic(8);
        put_ihdr(IHDR_BODY, 32'h7FFF_FFFF, 32'h0000_0001);
        put_iend();
        send_file();
        put_magic(8);
        put_ihdr(IHDR_BODY, 32'h8000_0000, 32'hFFFF_FFFF);
        put_iend();
        send_file();
        put_magic(8);
        put_ihdr(32'd5, 32'h0000_0001, 32'h0000_0002);
        put_iend();
        send_file();
        put_magic(8);
        put_ihdr(IHDR_BODY, 32'h0000_0003, 32'h0000_0004);
        put_ihdr(32'd20, 32'h0000_0000, 32'h0000_0009);
        put_iend();
        send_file();
        put_magic(8);
        put_ihdr(IHDR_BODY, 32'h0000_000A, 32'h0000_0014);
        put_word(IHDR_BODY);
        put_word(TYPE_IHDR);
        put_word(32'h0000_0055);
        put_random(2);
        send_file();
    endtask

    task automatic test_huge_lengths();
        put_magic(8);
        put_word(32'hFFFF_FFFF);
        put_word(TYPE_TEXT);
        put_random(6);
        send_file();
        put_magic(8);
        put_word(32'hFFFF_FFFF);
        put_word(TYPE_IHDR);
        put_word(32'h0000_0280);
        put_word(32'h0000_01E0);
        put_random(8);
        send_file();
    endtask

    task automatic test_random_files();
        int          first_byte;
        int          kind;
        int          cut;
        logic [31:0] len;
        first_byte = bytes_sent;
        while (bytes_sent - first_byte < RANDOM_BYTES)
        begin
            idle_on = (bytes_sent - first_byte < RANDOM_QUIET_FROM) && $urandom_range(0, 3) != 0;
            kind = $urandom_range(0, 9);
            if (kind == 0)
                put_random($urandom_range(1, 12));
            else if (kind == 1)
            begin
                put_magic(8);
                cut = $urandom_range(0, 7);
                file_bytes[cut] = file_bytes[cut] ^ (8'h01 << $urandom_range(0, 7));
                put_random($urandom_range(0, 6));
            end
            else
            begin
                put_magic(8);
                if ($urandom_range(0, 4) != 0)
                    put_ihdr(pick_ihdr_length(), pick_dim(), pick_dim());
                repeat ($urandom_range(0, 3))
                begin
                    if ($urandom_range(0, 7) == 0)
                        put_ihdr(pick_ihdr_length(), pick_dim(), pick_dim());
                    else
                    begin
                        len = $urandom_range(0, 16);
                        put_chunk(len, pick_type());
                    end
                end
                if (kind <= 7)
                begin
                    put_iend();
                    put_random($urandom_range(0, 3));
                end
                if (kind == 8)
                begin
                    cut = $urandom_range(1, file_bytes.size() - 1);
                    while (file_bytes.size() > cut)
                        void'(file_bytes.pop_back());
                end
            end
            send_file();
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        byte_valid = 1'b0;
        byte_beat = '0;
        clear_walker();
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        idle_on = 1'b1;
        test_signature_errors();
        test_iend_paths();
        test_ihdr_variants();
        test_huge_lengths();
        test_random_files();
        idle_on = 1'b0;
        byte_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/png_csw_pkg.sv
rtl/core/png_chunk_stream_walker.sv
bench/tb_top.sv
